FILE: rtl/ljmdf_pkg.sv
// Shared types, codes and helper functions for the LJ/MDF pair force block.
package ljmdf_pkg;

    localparam logic [63:0] MAG_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

    typedef enum logic [2:0] {
        CFG_REP_COEF,
        CFG_ATT_COEF,
        CFG_REP_E_COEF,
        CFG_ATT_E_COEF,
        CFG_OUTER_CUT_SQ,
        CFG_INNER_CUT_SQ,
        CFG_OUTER_CUT,
        CFG_INNER_CUT
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SH0,
        SH16,
        SH32,
        SH48
    } shift_t;

    typedef enum logic [4:0] {
        OP_SQ0, OP_SQ1, OP_SQ2,
        OP_DIV_R2, OP_MUL_T, OP_MUL_R6,
        OP_MUL_FA, OP_MUL_F, OP_MUL_EA, OP_MUL_E,
        OP_SQRT, OP_DIV_D, OP_SET_D,
        OP_MUL_D2, OP_MUL_DD2, OP_MUL_DD3, OP_MUL_TT, OP_MUL_G,
        OP_DIV_RD, OP_MUL_DT, OP_MUL_FT, OP_MUL_FB, OP_MUL_ET,
        OP_MUL_P1, OP_MUL_P2, OP_MUL_X, OP_MUL_Y, OP_MUL_Z, OP_MUL_EN
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_RANGE, ST_TAPER, ST_DSEL, ST_OUT,
        ST_SQ0, ST_SQ1, ST_SQ2,
        ST_DIV_R2, ST_MUL_T, ST_MUL_R6,
        ST_MUL_FA, ST_MUL_F, ST_MUL_EA, ST_MUL_E,
        ST_SQRT, ST_DIV_D, ST_SET_D,
        ST_MUL_D2, ST_MUL_DD2, ST_MUL_DD3, ST_MUL_TT, ST_MUL_G,
        ST_DIV_RD, ST_MUL_DT, ST_MUL_FT, ST_MUL_FB, ST_MUL_ET,
        ST_MUL_P1, ST_MUL_P2, ST_MUL_X, ST_MUL_Y, ST_MUL_Z, ST_MUL_EN
    } state_t;

    typedef struct packed {
        logic load;
        logic go;
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic inr;
        logic taper;
        logic d_full;
        logic out_free;
    } stat_t;

    function automatic logic [63:0] to_s64(input logic neg, input logic [63:0] mag);
        logic [63:0] v;
        if (!neg) begin
            v = (mag > S64_MAX) ? S64_MAX : mag;
        end else begin
            v = (mag >= S64_MIN) ? S64_MIN : (64'd0 - mag);
        end
        return v;
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            s = a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

endpackage

FILE: rtl/lj_mdf_pair_force.sv
// Lennard-Jones 12-6 pair force with MDF taper, one neighbor pair per request.
//
// Input channel (s_*): one neighbor pair per request: displacement, bond
// weight and last-neighbor mark. Result channel (m_*): pair force, energy,
// in-range flag, and on the last neighbor the summed central-atom force.
// Config channel (cfg_*): always ready; write registers only while idle.
//
// One request is processed at a time by a controller that steps a shared
// datapath: a 64x64 multiplier built from four 32x32 partial products, a
// bit-serial divider (96 or 128 iterations) and a bit-pair square root (32
// iterations). A pair beyond the cutoff goes to its result after the squared
// distance; an untapered pair skips the taper steps; a saturating divide ends
// early. The next request can be accepted in the cycle after the previous
// result is loaded.
// The result register frees the controller: the next request is accepted
// while a result waits for m_ready; a stalled receiver holds the block at
// its result step. Reset clears config registers, accumulators and control.
module lj_mdf_pair_force (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_disp_x,
    input  logic signed [31:0]  s_disp_y,
    input  logic signed [31:0]  s_disp_z,
    input  logic [16:0]         s_bond_weight,
    input  logic                s_last_neighbor,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_pair_fx,
    output logic signed [63:0]  m_pair_fy,
    output logic signed [63:0]  m_pair_fz,
    output logic signed [63:0]  m_pair_energy,
    output logic                m_in_range,
    output logic signed [63:0]  m_atom_fx,
    output logic signed [63:0]  m_atom_fy,
    output logic signed [63:0]  m_atom_fz,
    output logic                m_atom_done
);
    import ljmdf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    ljmdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ljmdf_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_disp_x        (s_disp_x),
        .s_disp_y        (s_disp_y),
        .s_disp_z        (s_disp_z),
        .s_bond_weight   (s_bond_weight),
        .s_last_neighbor (s_last_neighbor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pair_fx       (m_pair_fx),
        .m_pair_fy       (m_pair_fy),
        .m_pair_fz       (m_pair_fz),
        .m_pair_energy   (m_pair_energy),
        .m_in_range      (m_in_range),
        .m_atom_fx       (m_atom_fx),
        .m_atom_fy       (m_atom_fy),
        .m_atom_fz       (m_atom_fz),
        .m_atom_done     (m_atom_done)
    );

endmodule

FILE: rtl/ljmdf_mul.sv
// Shared 64x64 multiplier: four 32x32 partial products, then shift and saturate.
module ljmdf_mul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [63:0]          a,
    input  logic [63:0]          b,
    input  ljmdf_pkg::shift_t    sh,
    output logic                 done,
    output logic [63:0]          res
);
    import ljmdf_pkg::*;

    logic [63:0]  a_reg, b_reg, pp_reg, res_reg;
    logic [127:0] acc_reg, ppx;
    shift_t       sh_reg;
    logic [1:0]   pos_reg, pos_next;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  pa, pb;
    logic [63:0]  prod, fin;
    logic         sat;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0: begin pa = a_reg[31:0];  pb = b_reg[31:0];  pos_next = 2'd0; end
            2'd1: begin pa = a_reg[31:0];  pb = b_reg[63:32]; pos_next = 2'd1; end
            2'd2: begin pa = a_reg[63:32]; pb = b_reg[31:0];  pos_next = 2'd1; end
            default: begin pa = a_reg[63:32]; pb = b_reg[63:32]; pos_next = 2'd2; end
        endcase
        prod = pa * pb;
        case (pos_reg)
            2'd0:    ppx = {64'd0, pp_reg};
            2'd1:    ppx = {32'd0, pp_reg, 32'd0};
            default: ppx = {pp_reg, 64'd0};
        endcase
        case (sh_reg)
            SH0:     begin sat = |acc_reg[127:64]; fin = acc_reg[63:0];   end
            SH16:    begin sat = |acc_reg[127:80]; fin = acc_reg[79:16];  end
            SH32:    begin sat = |acc_reg[127:96]; fin = acc_reg[95:32];  end
            default: begin sat = |acc_reg[127:112]; fin = acc_reg[111:48]; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            sh_reg  <= sh;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg < 3'd4) begin
                pp_reg  <= prod;
                pos_reg <= pos_next;
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4) begin
                acc_reg <= acc_reg + ppx;
            end
            if (cnt_reg == 3'd5) begin
                res_reg <= sat ? MAG_MAX : fin;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: rtl/ljmdf_div.sv
// Restoring divider, one quotient bit per cycle: floor(num * 2^f / den), saturated.
module ljmdf_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    input  logic        f64,
    output logic        done,
    output logic [63:0] res
);
    import ljmdf_pkg::*;

    logic [63:0] n_reg, den_reg, r_reg, q_reg, res_reg;
    logic [7:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [63:0] rn, qn;
    logic        take;

    always_comb begin
        rn   = {r_reg[62:0], n_reg[63]};
        qn   = {q_reg[62:0], 1'b0};
        take = r_reg[63] || (rn >= den_reg);
        if (take) begin
            rn    = rn - den_reg;
            qn[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (den == 64'd0) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= f64 ? 8'd128 : 8'd96;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 8'd1;
                if (q_reg[63] || cnt_reg == 8'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= num;
            den_reg <= den;
            r_reg   <= '0;
            q_reg   <= '0;
            res_reg <= MAG_MAX;
        end else if (busy_reg) begin
            n_reg <= {n_reg[62:0], 1'b0};
            r_reg <= rn;
            q_reg <= qn;
            if (q_reg[63]) begin
                res_reg <= MAG_MAX;
            end else begin
                res_reg <= qn;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: rtl/ljmdf_dp.sv
// Datapath: config registers, operand routing, shared units, accumulators, result register.
module ljmdf_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ljmdf_pkg::cmd_t      cmd,
    output ljmdf_pkg::stat_t     stat,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [47:0]          cfg_data,
    input  logic signed [31:0]   s_disp_x,
    input  logic signed [31:0]   s_disp_y,
    input  logic signed [31:0]   s_disp_z,
    input  logic [16:0]          s_bond_weight,
    input  logic                 s_last_neighbor,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [63:0]   m_pair_fx,
    output logic signed [63:0]   m_pair_fy,
    output logic signed [63:0]   m_pair_fz,
    output logic signed [63:0]   m_pair_energy,
    output logic                 m_in_range,
    output logic signed [63:0]   m_atom_fx,
    output logic signed [63:0]   m_atom_fy,
    output logic signed [63:0]   m_atom_fz,
    output logic                 m_atom_done
);
    import ljmdf_pkg::*;

    logic [47:0] rep_coef_reg, att_coef_reg, rep_e_coef_reg, att_e_coef_reg;
    logic [47:0] outer_cut_sq_reg, inner_cut_sq_reg;
    logic [31:0] outer_cut_reg, inner_cut_reg;

    logic [31:0] dm_reg [3];
    logic [2:0]  dn_reg;
    logic [16:0] weight_reg;
    logic        last_reg;

    logic [63:0] rsq_reg, r2inv_reg, r6inv_reg, fmag_reg, emag_reg, tmp_reg;
    logic [63:0] d_reg, d2_reg, dd2_reg, tt_reg, g_reg, dt_reg, energy_reg;
    logic [63:0] pf_reg [3];
    logic [63:0] sum_reg [3];
    logic [31:0] rr_reg;
    logic        fneg_reg, eneg_reg;
    op_t         op_reg;

    logic [63:0] sq_n_reg, sq_r_reg, sq_bit_reg, sq_t;
    logic [4:0]  sq_cnt_reg;
    logic        sq_busy_reg, sq_done_reg, sq_start;
    logic        simple_done_reg;

    logic        mul_start, mul_done, div_start, div_done, div_f64;
    logic [63:0] mul_a, mul_b, mul_res, div_num, div_den, div_res;
    shift_t      mul_sh;

    logic [31:0] dp_w, num_w;
    logic [63:0] dd_w, poly_w, fa_b, ea_b, pf_new;
    logic [64:0] sm_sum;
    logic [63:0] sm_mag;
    logic        sm_neg, done_any, m_valid_reg;
    logic [1:0]  axis;
    logic [31:0] dm_in [3];

    assign dp_w   = (outer_cut_reg > inner_cut_reg) ? outer_cut_reg - inner_cut_reg : 32'd0;
    assign num_w  = (rr_reg > inner_cut_reg) ? rr_reg - inner_cut_reg : 32'd0;
    assign dd_w   = ONE_Q32 - d_reg;
    assign poly_w = ONE_Q32 + (d_reg << 1) + d_reg + (d2_reg << 2) + (d2_reg << 1);
    assign fa_b   = {att_coef_reg, 16'd0};
    assign ea_b   = {att_e_coef_reg, 16'd0};
    assign sq_t   = sq_r_reg + sq_bit_reg;

    assign dm_in[0] = s_disp_x[31] ? 32'd0 - s_disp_x : s_disp_x;
    assign dm_in[1] = s_disp_y[31] ? 32'd0 - s_disp_y : s_disp_y;
    assign dm_in[2] = s_disp_z[31] ? 32'd0 - s_disp_z : s_disp_z;

    always_comb begin
        sm_sum = {1'b0, tmp_reg} + {1'b0, mul_res};
        if (fneg_reg == eneg_reg) begin
            sm_neg = fneg_reg;
            sm_mag = sm_sum[64] ? MAG_MAX : sm_sum[63:0];
        end else if (tmp_reg >= mul_res) begin
            sm_neg = fneg_reg;
            sm_mag = tmp_reg - mul_res;
        end else begin
            sm_neg = eneg_reg;
            sm_mag = mul_res - tmp_reg;
        end
        case (op_reg)
            OP_MUL_Y: axis = 2'd1;
            OP_MUL_Z: axis = 2'd2;
            default:  axis = 2'd0;
        endcase
        pf_new = to_s64(fneg_reg ^ dn_reg[axis], mul_res);
    end

    always_comb begin
        mul_start = 1'b0;
        div_start = 1'b0;
        sq_start  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_sh    = SH32;
        div_num   = '0;
        div_den   = '0;
        div_f64   = 1'b0;
        case (cmd.op)
            OP_SQ0: begin
                mul_start = cmd.go; mul_a = {32'd0, dm_reg[0]}; mul_b = mul_a; mul_sh = SH0;
            end
            OP_SQ1: begin
                mul_start = cmd.go; mul_a = {32'd0, dm_reg[1]}; mul_b = mul_a; mul_sh = SH0;
            end
            OP_SQ2: begin
                mul_start = cmd.go; mul_a = {32'd0, dm_reg[2]}; mul_b = mul_a; mul_sh = SH0;
            end
            OP_DIV_R2: begin
                div_start = cmd.go; div_num = 64'h1_0000; div_den = rsq_reg; div_f64 = 1'b1;
            end
            OP_MUL_T: begin
                mul_start = cmd.go; mul_a = r2inv_reg; mul_b = r2inv_reg; mul_sh = SH48;
            end
            OP_MUL_R6: begin
                mul_start = cmd.go; mul_a = tmp_reg; mul_b = r2inv_reg; mul_sh = SH48;
            end
            OP_MUL_FA: begin
                mul_start = cmd.go; mul_a = {16'd0, rep_coef_reg}; mul_b = r6inv_reg;
            end
            OP_MUL_F: begin
                mul_start = cmd.go; mul_a = r6inv_reg; mul_b = fmag_reg; mul_sh = SH48;
            end
            OP_MUL_EA: begin
                mul_start = cmd.go; mul_a = {16'd0, rep_e_coef_reg}; mul_b = r6inv_reg;
            end
            OP_MUL_E: begin
                mul_start = cmd.go; mul_a = r6inv_reg; mul_b = emag_reg; mul_sh = SH48;
            end
            OP_SQRT:    sq_start = cmd.go;
            OP_DIV_D: begin
                div_start = cmd.go; div_num = {32'd0, num_w}; div_den = {32'd0, dp_w};
            end
            OP_MUL_D2:  begin mul_start = cmd.go; mul_a = d_reg;   mul_b = d_reg;   end
            OP_MUL_DD2: begin mul_start = cmd.go; mul_a = dd_w;    mul_b = dd_w;    end
            OP_MUL_DD3: begin mul_start = cmd.go; mul_a = dd2_reg; mul_b = dd_w;    end
            OP_MUL_TT:  begin mul_start = cmd.go; mul_a = poly_w;  mul_b = tmp_reg; end
            OP_MUL_G:   begin mul_start = cmd.go; mul_a = d2_reg;  mul_b = dd2_reg; end
            OP_DIV_RD: begin
                div_start = cmd.go; div_num = {32'd0, rr_reg}; div_den = {32'd0, dp_w};
            end
            OP_MUL_DT:  begin mul_start = cmd.go; mul_a = g_reg;    mul_b = tmp_reg; end
            OP_MUL_FT:  begin mul_start = cmd.go; mul_a = fmag_reg; mul_b = tt_reg;  end
            OP_MUL_FB:  begin mul_start = cmd.go; mul_a = emag_reg; mul_b = dt_reg;  end
            OP_MUL_ET:  begin mul_start = cmd.go; mul_a = emag_reg; mul_b = tt_reg;  end
            OP_MUL_P1: begin
                mul_start = cmd.go; mul_a = fmag_reg; mul_b = r2inv_reg; mul_sh = SH48;
            end
            OP_MUL_P2: begin
                mul_start = cmd.go; mul_a = tmp_reg; mul_b = {47'd0, weight_reg}; mul_sh = SH16;
            end
            OP_MUL_X: begin
                mul_start = cmd.go; mul_a = {32'd0, dm_reg[0]}; mul_b = tmp_reg; mul_sh = SH16;
            end
            OP_MUL_Y: begin
                mul_start = cmd.go; mul_a = {32'd0, dm_reg[1]}; mul_b = tmp_reg; mul_sh = SH16;
            end
            OP_MUL_Z: begin
                mul_start = cmd.go; mul_a = {32'd0, dm_reg[2]}; mul_b = tmp_reg; mul_sh = SH16;
            end
            OP_MUL_EN: begin
                mul_start = cmd.go; mul_a = emag_reg; mul_b = {47'd0, weight_reg}; mul_sh = SH16;
            end
            default: ;
        endcase
    end

    ljmdf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .sh      (mul_sh),
        .done    (mul_done),
        .res     (mul_res)
    );

    ljmdf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .f64     (div_f64),
        .done    (div_done),
        .res     (div_res)
    );

    assign done_any = mul_done | div_done | sq_done_reg | simple_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_coef_reg     <= '0;
            att_coef_reg     <= '0;
            rep_e_coef_reg   <= '0;
            att_e_coef_reg   <= '0;
            outer_cut_sq_reg <= '0;
            inner_cut_sq_reg <= '0;
            outer_cut_reg    <= '0;
            inner_cut_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_REP_COEF:     rep_coef_reg     <= cfg_data;
                CFG_ATT_COEF:     att_coef_reg     <= cfg_data;
                CFG_REP_E_COEF:   rep_e_coef_reg   <= cfg_data;
                CFG_ATT_E_COEF:   att_e_coef_reg   <= cfg_data;
                CFG_OUTER_CUT_SQ: outer_cut_sq_reg <= cfg_data;
                CFG_INNER_CUT_SQ: inner_cut_sq_reg <= cfg_data;
                CFG_OUTER_CUT:    outer_cut_reg    <= cfg_data[31:0];
                CFG_INNER_CUT:    inner_cut_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_busy_reg     <= 1'b0;
            sq_done_reg     <= 1'b0;
            sq_cnt_reg      <= '0;
            simple_done_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            sq_done_reg     <= 1'b0;
            simple_done_reg <= cmd.go && (cmd.op == OP_SET_D);
            if (sq_start) begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= 5'd31;
            end else if (sq_busy_reg) begin
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
                if (sq_cnt_reg == 5'd0) begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_start) begin
            sq_n_reg   <= rsq_reg;
            sq_r_reg   <= '0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end else if (sq_busy_reg) begin
            if (sq_n_reg >= sq_t) begin
                sq_n_reg <= sq_n_reg - sq_t;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end else begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            sum_reg[2] <= '0;
        end else if (cmd.out_load && last_reg) begin
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            sum_reg[2] <= '0;
        end else if (done_any && (op_reg == OP_MUL_X || op_reg == OP_MUL_Y
                                  || op_reg == OP_MUL_Z)) begin
            sum_reg[axis] <= sat_add64(sum_reg[axis], pf_new);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.go) begin
            op_reg <= cmd.op;
        end
        if (cmd.load) begin
            dm_reg[0]  <= dm_in[0];
            dm_reg[1]  <= dm_in[1];
            dm_reg[2]  <= dm_in[2];
            dn_reg     <= {s_disp_z[31], s_disp_y[31], s_disp_x[31]};
            weight_reg <= s_bond_weight;
            last_reg   <= s_last_neighbor;
            pf_reg[0]  <= '0;
            pf_reg[1]  <= '0;
            pf_reg[2]  <= '0;
            energy_reg <= '0;
        end else if (done_any) begin
            case (op_reg)
                OP_SQ0:     rsq_reg   <= mul_res;
                OP_SQ1:     rsq_reg   <= rsq_reg + mul_res;
                OP_SQ2:     rsq_reg   <= rsq_reg + mul_res;
                OP_DIV_R2:  r2inv_reg <= div_res;
                OP_MUL_T:   tmp_reg   <= mul_res;
                OP_MUL_R6:  r6inv_reg <= mul_res;
                OP_MUL_FA: begin
                    fneg_reg <= mul_res < fa_b;
                    fmag_reg <= (mul_res >= fa_b) ? mul_res - fa_b : fa_b - mul_res;
                end
                OP_MUL_F:   fmag_reg  <= mul_res;
                OP_MUL_EA: begin
                    eneg_reg <= mul_res < ea_b;
                    emag_reg <= (mul_res >= ea_b) ? mul_res - ea_b : ea_b - mul_res;
                end
                OP_MUL_E:   emag_reg  <= mul_res;
                OP_SQRT:    rr_reg    <= sq_r_reg[31:0];
                OP_DIV_D:   d_reg     <= div_res;
                OP_SET_D:   d_reg     <= ONE_Q32;
                OP_MUL_D2:  d2_reg    <= mul_res;
                OP_MUL_DD2: dd2_reg   <= mul_res;
                OP_MUL_DD3: tmp_reg   <= mul_res;
                OP_MUL_TT:  tt_reg    <= mul_res;
                OP_MUL_G:   g_reg     <= (mul_res << 5) - (mul_res << 1);
                OP_DIV_RD:  tmp_reg   <= div_res;
                OP_MUL_DT:  dt_reg    <= mul_res;
                OP_MUL_FT:  tmp_reg   <= mul_res;
                OP_MUL_FB: begin
                    fmag_reg <= sm_mag;
                    fneg_reg <= sm_neg;
                end
                OP_MUL_ET:  emag_reg  <= mul_res;
                OP_MUL_P1:  tmp_reg   <= mul_res;
                OP_MUL_P2:  tmp_reg   <= mul_res;
                OP_MUL_X:   pf_reg[0] <= pf_new;
                OP_MUL_Y:   pf_reg[1] <= pf_new;
                OP_MUL_Z:   pf_reg[2] <= pf_new;
                OP_MUL_EN:  energy_reg <= to_s64(eneg_reg, mul_res);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_pair_fx     <= pf_reg[0];
            m_pair_fy     <= pf_reg[1];
            m_pair_fz     <= pf_reg[2];
            m_pair_energy <= energy_reg;
            m_in_range    <= stat.inr;
            m_atom_fx     <= last_reg ? sum_reg[0] : 64'd0;
            m_atom_fy     <= last_reg ? sum_reg[1] : 64'd0;
            m_atom_fz     <= last_reg ? sum_reg[2] : 64'd0;
            m_atom_done   <= last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign stat.done     = done_any;
    assign stat.inr      = rsq_reg < {outer_cut_sq_reg, 16'd0};
    assign stat.taper    = rsq_reg > {inner_cut_sq_reg, 16'd0};
    assign stat.d_full   = num_w >= dp_w;
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

FILE: rtl/ljmdf_ctrl.sv
// Controller: sequences the datapath operations for one neighbor pair.
module ljmdf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ljmdf_pkg::stat_t    stat,
    output ljmdf_pkg::cmd_t     cmd
);
    import ljmdf_pkg::*;

    state_t state_reg, state_next;
    logic   pending_reg, pending_next;
    logic   has_op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_SQ0;
            ST_SQ0:     if (stat.done) state_next = ST_SQ1;
            ST_SQ1:     if (stat.done) state_next = ST_SQ2;
            ST_SQ2:     if (stat.done) state_next = ST_RANGE;
            ST_RANGE:   state_next = stat.inr ? ST_DIV_R2 : ST_OUT;
            ST_DIV_R2:  if (stat.done) state_next = ST_MUL_T;
            ST_MUL_T:   if (stat.done) state_next = ST_MUL_R6;
            ST_MUL_R6:  if (stat.done) state_next = ST_MUL_FA;
            ST_MUL_FA:  if (stat.done) state_next = ST_MUL_F;
            ST_MUL_F:   if (stat.done) state_next = ST_MUL_EA;
            ST_MUL_EA:  if (stat.done) state_next = ST_MUL_E;
            ST_MUL_E:   if (stat.done) state_next = ST_TAPER;
            ST_TAPER:   state_next = stat.taper ? ST_SQRT : ST_MUL_P1;
            ST_SQRT:    if (stat.done) state_next = ST_DSEL;
            ST_DSEL:    state_next = stat.d_full ? ST_SET_D : ST_DIV_D;
            ST_DIV_D:   if (stat.done) state_next = ST_MUL_D2;
            ST_SET_D:   if (stat.done) state_next = ST_MUL_D2;
            ST_MUL_D2:  if (stat.done) state_next = ST_MUL_DD2;
            ST_MUL_DD2: if (stat.done) state_next = ST_MUL_DD3;
            ST_MUL_DD3: if (stat.done) state_next = ST_MUL_TT;
            ST_MUL_TT:  if (stat.done) state_next = ST_MUL_G;
            ST_MUL_G:   if (stat.done) state_next = ST_DIV_RD;
            ST_DIV_RD:  if (stat.done) state_next = ST_MUL_DT;
            ST_MUL_DT:  if (stat.done) state_next = ST_MUL_FT;
            ST_MUL_FT:  if (stat.done) state_next = ST_MUL_FB;
            ST_MUL_FB:  if (stat.done) state_next = ST_MUL_ET;
            ST_MUL_ET:  if (stat.done) state_next = ST_MUL_P1;
            ST_MUL_P1:  if (stat.done) state_next = ST_MUL_P2;
            ST_MUL_P2:  if (stat.done) state_next = ST_MUL_X;
            ST_MUL_X:   if (stat.done) state_next = ST_MUL_Y;
            ST_MUL_Y:   if (stat.done) state_next = ST_MUL_Z;
            ST_MUL_Z:   if (stat.done) state_next = ST_MUL_EN;
            ST_MUL_EN:  if (stat.done) state_next = ST_OUT;
            ST_OUT:     if (stat.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        has_op  = 1'b1;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                has_op   = 1'b0;
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_OUT: begin
                has_op       = 1'b0;
                cmd.out_load = stat.out_free;
            end
            ST_SQ0:     cmd.op = OP_SQ0;
            ST_SQ1:     cmd.op = OP_SQ1;
            ST_SQ2:     cmd.op = OP_SQ2;
            ST_DIV_R2:  cmd.op = OP_DIV_R2;
            ST_MUL_T:   cmd.op = OP_MUL_T;
            ST_MUL_R6:  cmd.op = OP_MUL_R6;
            ST_MUL_FA:  cmd.op = OP_MUL_FA;
            ST_MUL_F:   cmd.op = OP_MUL_F;
            ST_MUL_EA:  cmd.op = OP_MUL_EA;
            ST_MUL_E:   cmd.op = OP_MUL_E;
            ST_SQRT:    cmd.op = OP_SQRT;
            ST_DIV_D:   cmd.op = OP_DIV_D;
            ST_SET_D:   cmd.op = OP_SET_D;
            ST_MUL_D2:  cmd.op = OP_MUL_D2;
            ST_MUL_DD2: cmd.op = OP_MUL_DD2;
            ST_MUL_DD3: cmd.op = OP_MUL_DD3;
            ST_MUL_TT:  cmd.op = OP_MUL_TT;
            ST_MUL_G:   cmd.op = OP_MUL_G;
            ST_DIV_RD:  cmd.op = OP_DIV_RD;
            ST_MUL_DT:  cmd.op = OP_MUL_DT;
            ST_MUL_FT:  cmd.op = OP_MUL_FT;
            ST_MUL_FB:  cmd.op = OP_MUL_FB;
            ST_MUL_ET:  cmd.op = OP_MUL_ET;
            ST_MUL_P1:  cmd.op = OP_MUL_P1;
            ST_MUL_P2:  cmd.op = OP_MUL_P2;
            ST_MUL_X:   cmd.op = OP_MUL_X;
            ST_MUL_Y:   cmd.op = OP_MUL_Y;
            ST_MUL_Z:   cmd.op = OP_MUL_Z;
            ST_MUL_EN:  cmd.op = OP_MUL_EN;
            default:    has_op = 1'b0;
        endcase
        cmd.go = has_op && !pending_reg;
    end

    always_comb begin
        pending_next = pending_reg;
        if (cmd.go) begin
            pending_next = 1'b1;
        end
        if (stat.done) begin
            pending_next = 1'b0;
        end
    end

endmodule

FILE: rtl/ljmdf_chk.sv
// Port-level checker for the pair force block, bound to the top level.
module ljmdf_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [63:0]  m_pair_fx,
    input logic signed [63:0]  m_pair_fy,
    input logic signed [63:0]  m_pair_fz,
    input logic signed [63:0]  m_pair_energy,
    input logic                m_in_range,
    input logic signed [63:0]  m_atom_fx,
    input logic signed [63:0]  m_atom_fy,
    input logic signed [63:0]  m_atom_fz,
    input logic                m_atom_done
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while the previous one is in work");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pair_fx) && $stable(m_pair_energy)
            && $stable(m_atom_fx) && $stable(m_atom_done))
        else $error("stalled result changed");

    a_out_of_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> m_pair_fx == 64'sd0 && m_pair_fy == 64'sd0
            && m_pair_fz == 64'sd0 && m_pair_energy == 64'sd0)
        else $error("out-of-range pair gives nonzero force or energy");

    a_atom_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_atom_done |-> m_atom_fx == 64'sd0 && m_atom_fy == 64'sd0
            && m_atom_fz == 64'sd0)
        else $error("atom force shown on a pair that is not the last neighbor");

endmodule

bind lj_mdf_pair_force ljmdf_chk u_chk (.*);
